/* hw/rtl/crpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_pkg
// Types and constants shared by the Catmull-Rom path evaluator.
// ----------------------------------------------------------------------------
package crpe_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int ADDR_W      = 6;
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int WT_FRAC     = 24;
  localparam int WEIGHT_W    = 30;
  localparam int COUNT_W     = 7;
  localparam int SEG_W       = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic signed [31:0] WT_ONE = 32'sd16777216;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] idx;
    point_t            pt;
    logic [SEG_W-1:0]  seg;
    weight_t [3:0]     wp;
    weight_t [3:0]     wd;
  } prep_item_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    weight_t          wp;
    weight_t          wd;
    logic [SEG_W-1:0] seg;
  } blend_ctl_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] cnt;
  } seq_stat_t;

  typedef struct packed {
    coord_t           pos_x;
    coord_t           pos_y;
    coord_t           pos_z;
    coord_t           tangent_x;
    coord_t           tangent_y;
    coord_t           tangent_z;
    logic [SEG_W-1:0] segment;
  } result_t;

endpackage

/* hw/rtl/crpe_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_req_if
// Request channel: point writes and path evaluations.
// ----------------------------------------------------------------------------
interface crpe_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [5:0]         point_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [15:0]        path_position;

  modport source (
    output valid, opcode, point_index, coord_x, coord_y, coord_z, path_position,
    input  ready
  );
  modport sink (
    input  valid, opcode, point_index, coord_x, coord_y, coord_z, path_position,
    output ready
  );
endinterface

/* hw/rtl/crpe_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_res_if
// Result channel: curve position, tangent and segment.
// ----------------------------------------------------------------------------
interface crpe_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tangent_x;
  logic signed [31:0] tangent_y;
  logic signed [31:0] tangent_z;
  logic [5:0]         segment;

  modport source (
    output valid, pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z, segment,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z, segment,
    output ready
  );
endinterface

/* hw/rtl/catmull_rom_path_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_path_evaluator
// Uniform Catmull-Rom position and tangent from a table of 3-D control points.
//
//   channel  dir  handshake      carries
//   req      in   valid/ready    opcode, point_index, coord_x/y/z, path_position
//   res      out  valid/ready    pos_x/y/z, tangent_x/y/z, segment
//   cfg      in   cfg_we         point_count
//
// A point write is one memory write; an evaluation makes four reads, one after
// another, through the single read port of the control point memory. Reset
// clears control state only; the point memory is not cleared. A stalled result
// channel holds results in a four-entry queue and then stops new evaluations at
// the sequencer.
// ----------------------------------------------------------------------------
module catmull_rom_path_evaluator (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  crpe_req_if.sink   req,
  crpe_res_if.source res
);
  import crpe_pkg::*;

  logic [COUNT_W-1:0] point_count;
  point_t             req_pt;
  logic               p4_valid;
  prep_item_t         p4_item;
  logic               take;
  logic               start;
  logic               credit_ok;
  logic [2:0]         inflight;
  logic [2:0]         inflight_next;
  point_t             rd_pt;
  blend_ctl_t         ctl;
  seq_stat_t          stat;
  logic               b_valid;
  result_t            b_res;
  logic               q_valid;
  result_t            q_res;
  logic [2:0]         q_count;
  logic               pop;

  assign req_pt    = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
  assign start     = take && (p4_item.op == OP_EVAL);
  assign pop       = q_valid && res.ready;
  assign credit_ok = (inflight < 3'(QUEUE_DEPTH));

  always_comb begin
    inflight_next = inflight + {2'b0, start} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_RESET;
      inflight    <= 3'd0;
    end else begin
      if (cfg_we) begin
        point_count <= cfg_data;
      end
      inflight <= inflight_next;
    end
  end

  crpe_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .op        (req.opcode),
    .idx       (req.point_index),
    .pt        (req_pt),
    .pos       (req.path_position),
    .count     (point_count),
    .take      (take),
    .out_valid (p4_valid),
    .out_item  (p4_item)
  );

  crpe_mem_seq u_mem_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p4_valid),
    .item      (p4_item),
    .credit_ok (credit_ok),
    .take      (take),
    .rd_pt     (rd_pt),
    .ctl       (ctl),
    .stat      (stat)
  );

  crpe_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .pt        (rd_pt),
    .ctl       (ctl),
    .res_valid (b_valid),
    .res       (b_res)
  );

  crpe_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .din   (b_res),
    .pop   (pop),
    .valid (q_valid),
    .dout  (q_res),
    .count (q_count)
  );

  assign res.valid     = q_valid;
  assign res.pos_x     = q_res.pos_x;
  assign res.pos_y     = q_res.pos_y;
  assign res.pos_z     = q_res.pos_z;
  assign res.tangent_x = q_res.tangent_x;
  assign res.tangent_y = q_res.tangent_y;
  assign res.tangent_z = q_res.tangent_z;
  assign res.segment   = q_res.segment;

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'(QUEUE_DEPTH))
    else $error("evaluations in flight exceed queue depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(b_valid && q_count == 3'(QUEUE_DEPTH)))
    else $error("result pushed into full queue");

  a_write_order: assert property (@(posedge clk) disable iff (rst)
    (take && p4_item.op == OP_WRITE) |-> (!stat.busy || stat.cnt == 2'd3))
    else $error("point write overtakes pending reads");

  a_start_reads: assert property (@(posedge clk) disable iff (rst)
    start |=> (ctl.valid == 1'b0 || ctl.last) ##1 (ctl.valid && ctl.first))
    else $error("evaluation did not issue its first read");

endmodule

/* hw/rtl/crpe_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_prep
// Four-stage front pipeline: segment split, t^2, t^3, basis weights.
// ----------------------------------------------------------------------------
module crpe_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [5:0]                  idx,
  input  crpe_pkg::point_t            pt,
  input  logic [15:0]                 pos,
  input  logic [6:0]                  count,
  input  logic                        take,
  output logic                        out_valid,
  output crpe_pkg::prep_item_t        out_item
);
  import crpe_pkg::*;

  logic                adv;
  logic [COUNT_W-1:0]  cnt_eff;
  logic [COUNT_W-1:0]  segs;
  logic [22:0]         prod;
  logic                v1, v2, v3, v4;
  logic                op1, op2, op3;
  logic [ADDR_W-1:0]   idx1, idx2, idx3;
  point_t              pt1, pt2, pt3;
  logic [SEG_W-1:0]    seg1, seg2, seg3;
  logic [23:0]         tw1, tw2, tw3;
  logic [24:0]         t2_2, t2_3, t3_3;
  logic [48:0]         sq_rnd;
  logic [49:0]         cube_rnd;
  logic signed [31:0]  a, b, c;
  logic signed [31:0]  wp_c [4];
  logic signed [31:0]  wd_c [4];

  assign adv       = !v4 || take;
  assign in_ready  = adv;
  assign out_valid = v4;

  always_comb begin
    if (count < COUNT_MIN) begin
      cnt_eff = COUNT_MIN;
    end else if (count > COUNT_MAX) begin
      cnt_eff = COUNT_MAX;
    end else begin
      cnt_eff = count;
    end
    segs = cnt_eff - 7'd3;
    prod = {7'b0, pos} * {16'b0, segs};
  end

  assign sq_rnd   = {25'b0, tw1} * {25'b0, tw1} + 49'h0800000;
  assign cube_rnd = {25'b0, t2_2} * {26'b0, tw2} + 50'h0800000;

  always_comb begin
    a = $signed({8'b0, tw3});
    b = $signed({7'b0, t2_3});
    c = $signed({7'b0, t3_3});
    wp_c[0] = -c + 2 * b - a;
    wp_c[1] = 3 * c - 5 * b + 2 * WT_ONE;
    wp_c[2] = -3 * c + 4 * b + a;
    wp_c[3] = c - b;
    wd_c[0] = -3 * b + 4 * a - WT_ONE;
    wd_c[1] = 9 * b - 10 * a;
    wd_c[2] = -9 * b + 8 * a + WT_ONE;
    wd_c[3] = 3 * b - 2 * a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= op;
      idx1 <= idx;
      pt1  <= pt;
      seg1 <= prod[21:16];
      tw1  <= {prod[15:0], 8'b0};

      op2  <= op1;
      idx2 <= idx1;
      pt2  <= pt1;
      seg2 <= seg1;
      tw2  <= tw1;
      t2_2 <= sq_rnd[48:24];

      op3  <= op2;
      idx3 <= idx2;
      pt3  <= pt2;
      seg3 <= seg2;
      tw3  <= tw2;
      t2_3 <= t2_2;
      t3_3 <= cube_rnd[48:24];

      out_item.op  <= op3;
      out_item.idx <= idx3;
      out_item.pt  <= pt3;
      out_item.seg <= seg3;
      for (int i = 0; i < 4; i++) begin
        out_item.wp[i] <= wp_c[i][WEIGHT_W-1:0];
        out_item.wd[i] <= wd_c[i][WEIGHT_W-1:0];
      end
    end
  end

endmodule

/* hw/rtl/crpe_mem_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_mem_seq
// Control point memory and read sequencer: one write or four reads per item.
// ----------------------------------------------------------------------------
module crpe_mem_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  crpe_pkg::prep_item_t   item,
  input  logic                   credit_ok,
  output logic                   take,
  output crpe_pkg::point_t       rd_pt,
  output crpe_pkg::blend_ctl_t   ctl,
  output crpe_pkg::seq_stat_t    stat
);
  import crpe_pkg::*;

  point_t            mem [MAX_POINTS];
  logic              busy;
  logic [1:0]        cnt;
  logic [SEG_W-1:0]  seg_r;
  weight_t [3:0]     wp_r;
  weight_t [3:0]     wd_r;
  logic              last;
  logic              free;
  logic              start;
  logic              wr_en;
  logic [SEG_W:0]    sum;
  logic [ADDR_W-1:0] raddr;

  assign last  = busy && (cnt == 2'd3);
  assign free  = !busy || last;
  assign take  = in_valid && free && (item.op == OP_WRITE || credit_ok);
  assign start = take && (item.op == OP_EVAL);
  assign wr_en = take && (item.op == OP_WRITE);
  assign sum   = {1'b0, seg_r} + {5'b0, cnt};
  assign raddr = sum[SEG_W] ? {ADDR_W{1'b1}} : sum[ADDR_W-1:0];
  assign stat  = '{busy: busy, cnt: cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= busy;
    end
    if (start) begin
      seg_r <= item.seg;
      wp_r  <= item.wp;
      wd_r  <= item.wd;
    end
    ctl.first <= (cnt == 2'd0);
    ctl.last  <= (cnt == 2'd3);
    ctl.wp    <= wp_r[cnt];
    ctl.wd    <= wd_r[cnt];
    ctl.seg   <= seg_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[item.idx] <= item.pt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pt <= mem[raddr];
  end

endmodule

/* hw/rtl/crpe_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_blend
// Weight-times-point products, accumulation over four points, round and clamp.
// ----------------------------------------------------------------------------
module crpe_blend (
  input  logic                  clk,
  input  logic                  rst,
  input  crpe_pkg::point_t      pt,
  input  crpe_pkg::blend_ctl_t  ctl,
  output logic                  res_valid,
  output crpe_pkg::result_t     res
);
  import crpe_pkg::*;

  logic signed [61:0] prod_c [6];
  logic signed [61:0] prod_r [6];
  logic signed [63:0] acc [6];
  logic               m_valid, m_first, m_last;
  logic [SEG_W-1:0]   m_seg, a_seg;
  logic               done;

  function automatic coord_t round_sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    logic signed [63:0] q;
    r = v + 64'sd16777216;
    q = r >>> 25;
    if (q > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (q < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return q[COORD_W-1:0];
  endfunction

  always_comb begin
    prod_c[0] = $signed(ctl.wp) * $signed(pt.x);
    prod_c[1] = $signed(ctl.wp) * $signed(pt.y);
    prod_c[2] = $signed(ctl.wp) * $signed(pt.z);
    prod_c[3] = $signed(ctl.wd) * $signed(pt.x);
    prod_c[4] = $signed(ctl.wd) * $signed(pt.y);
    prod_c[5] = $signed(ctl.wd) * $signed(pt.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      done      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      m_valid   <= ctl.valid;
      done      <= m_valid && m_last;
      res_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    m_first <= ctl.first;
    m_last  <= ctl.last;
    m_seg   <= ctl.seg;
    for (int i = 0; i < 6; i++) begin
      prod_r[i] <= prod_c[i];
    end
    if (m_valid) begin
      a_seg <= m_seg;
      for (int i = 0; i < 6; i++) begin
        acc[i] <= m_first ? 64'(prod_r[i]) : acc[i] + 64'(prod_r[i]);
      end
    end
    res.pos_x     <= round_sat(acc[0]);
    res.pos_y     <= round_sat(acc[1]);
    res.pos_z     <= round_sat(acc[2]);
    res.tangent_x <= round_sat(acc[3]);
    res.tangent_y <= round_sat(acc[4]);
    res.tangent_z <= round_sat(acc[5]);
    res.segment   <= a_seg;
  end

endmodule

/* hw/rtl/crpe_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_out_queue
// Small result queue between the blend pipeline and the result channel.
// ----------------------------------------------------------------------------
module crpe_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  crpe_pkg::result_t  din,
  input  logic               pop,
  output logic               valid,
  output crpe_pkg::result_t  dout,
  output logic [2:0]         count
);
  import crpe_pkg::*;

  result_t    slots [QUEUE_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;

  assign valid = (count != 3'd0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* bench/crpe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpe_checker
// Watches the request, result and configuration ports of the path evaluator.
// It keeps its own copy of the point tables and the point count, and predicts
// position, tangent and segment for every evaluate request. Each result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module crpe_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  crpe_req_if        req,
  crpe_res_if        res,
  output int         error_count,
  output int         pending_count,
  output int         result_count
);
  import crpe_pkg::*;

  typedef longint weight_vec_t [4];

  coord_t          table_x [MAX_POINTS];
  coord_t          table_y [MAX_POINTS];
  coord_t          table_z [MAX_POINTS];
  logic [6:0]      active_count;
  result_t         expected_results [$];

  function automatic coord_t blend_axis(weight_vec_t w, coord_t p0, coord_t p1,
                                        coord_t p2, coord_t p3);
    longint acc;
    longint q;
    acc = w[0] * longint'(p0) + w[1] * longint'(p1)
        + w[2] * longint'(p2) + w[3] * longint'(p3);
    q = (acc + (longint'(1) <<< 24)) >>> 25;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return coord_t'(q);
  endfunction

  function automatic result_t evaluate_curve(logic [15:0] position);
    result_t     r;
    longint      n;
    longint      prod;
    longint      seg;
    longint      tw;
    longint      t2;
    longint      t3;
    longint      one;
    weight_vec_t wp;
    weight_vec_t wd;
    coord_t      px [4];
    coord_t      py [4];
    coord_t      pz [4];
    n = active_count;
    if (n < 4) n = 4;
    if (n > MAX_POINTS) n = MAX_POINTS;
    prod = longint'(position) * (n - 3);
    seg  = prod >> 16;
    tw   = (prod & 64'hFFFF) << 8;
    one  = longint'(1) << 24;
    t2   = (tw * tw + (longint'(1) << 23)) >> 24;
    t3   = (t2 * tw + (longint'(1) << 23)) >> 24;
    wp[0] = -t3 + 2 * t2 - tw;
    wp[1] = 3 * t3 - 5 * t2 + 2 * one;
    wp[2] = -3 * t3 + 4 * t2 + tw;
    wp[3] = t3 - t2;
    wd[0] = -3 * t2 + 4 * tw - one;
    wd[1] = 9 * t2 - 10 * tw;
    wd[2] = -9 * t2 + 8 * tw + one;
    wd[3] = 3 * t2 - 2 * tw;
    for (int i = 0; i < 4; i++) begin
      px[i] = table_x[seg + i];
      py[i] = table_y[seg + i];
      pz[i] = table_z[seg + i];
    end
    r.pos_x     = blend_axis(wp, px[0], px[1], px[2], px[3]);
    r.pos_y     = blend_axis(wp, py[0], py[1], py[2], py[3]);
    r.pos_z     = blend_axis(wp, pz[0], pz[1], pz[2], pz[3]);
    r.tangent_x = blend_axis(wd, px[0], px[1], px[2], px[3]);
    r.tangent_y = blend_axis(wd, py[0], py[1], py[2], py[3]);
    r.tangent_z = blend_axis(wd, pz[0], pz[1], pz[2], pz[3]);
    r.segment   = seg[SEG_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  initial begin
    error_count   = 0;
    pending_count = 0;
    result_count  = 0;
    active_count  = COUNT_RESET;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      active_count = COUNT_RESET;
      expected_results.delete();
    end else begin
      if (res.valid && res.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("result with no pending evaluate request");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("pos_x", want.pos_x, res.pos_x);
          check_field("pos_y", want.pos_y, res.pos_y);
          check_field("pos_z", want.pos_z, res.pos_z);
          check_field("tangent_x", want.tangent_x, res.tangent_x);
          check_field("tangent_y", want.tangent_y, res.tangent_y);
          check_field("tangent_z", want.tangent_z, res.tangent_z);
          check_field("segment", want.segment, res.segment);
        end
      end
      if (req.valid && req.ready) begin
        if (req.opcode == OP_WRITE) begin
          table_x[req.point_index] = req.coord_x;
          table_y[req.point_index] = req.coord_y;
          table_z[req.point_index] = req.coord_z;
        end else begin
          expected_results.insert(expected_results.size(),
                                  evaluate_curve(req.path_position));
        end
      end
      if (cfg_we) active_count = cfg_data;
    end
    pending_count = expected_results.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Catmull-Rom path evaluator. Fills the point
// table, runs directed evaluations at the ends of the path and with extreme
// coordinates, then random write and evaluate traffic over several point
// counts and idle patterns on both channels. Checking is in crpe_checker.
// ----------------------------------------------------------------------------
module testbench;
  import crpe_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;
  int         error_count;
  int         pending_count;
  int         result_count;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         request_count = 0;

  crpe_req_if req ();
  crpe_res_if res ();

  catmull_rom_path_evaluator u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .res      (res)
  );

  crpe_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .req           (req),
    .res           (res),
    .error_count   (error_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_WRITE;
    req.point_index = '0;
    req.coord_x = '0;
    req.coord_y = '0;
    req.coord_z = '0;
    req.path_position = '0;
    res.ready = 1'b0;
  end

  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return coord_t'($urandom_range(2047)) - 32'sd1024;
      3, 4: return coord_t'($signed($urandom) >>> 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_request(logic op, logic [5:0] idx, coord_t x, coord_t y,
                              coord_t z, logic [15:0] position);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
      @(negedge clk);
    end
    req.opcode = op;
    req.point_index = idx;
    req.coord_x = x;
    req.coord_y = y;
    req.coord_z = z;
    req.path_position = position;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    request_count++;
  endtask

  task automatic write_point(logic [5:0] idx, coord_t x, coord_t y, coord_t z);
    send_request(OP_WRITE, idx, x, y, z, 16'($urandom));
  endtask

  task automatic eval_path(logic [15:0] position);
    send_request(OP_EVAL, 6'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), position);
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_point_count(logic [6:0] value);
    drain();
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int items, int idle_pct, int stall_pct,
                              logic [6:0] count);
    logic [15:0] position;
    set_point_count(count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain();
      if ($urandom_range(3) == 0) begin
        write_point(6'($urandom), pick_coord(), pick_coord(), pick_coord());
      end else begin
        case ($urandom_range(9))
          0: position = 16'h0000;
          1: position = 16'hFFFF;
          default: position = 16'($urandom);
        endcase
        eval_path(position);
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < MAX_POINTS; i++) begin
      write_point(i[5:0], pick_coord(), pick_coord(), pick_coord());
    end

    write_point(6'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    write_point(6'd1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    write_point(6'd2, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
    write_point(6'd3, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    eval_path(16'h0000);
    eval_path(16'hFFFF);
    eval_path(16'h8000);
    eval_path(16'h0001);
    eval_path(16'h5555);
    set_point_count(7'd64);
    write_point(6'd63, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
    eval_path(16'hFFFF);
    eval_path(16'h0000);
    eval_path(16'hAAAA);
    set_point_count(7'd0);
    eval_path(16'hFFFF);
    set_point_count(7'd127);
    eval_path(16'hFFFF);
    eval_path(16'h7FFF);

    for (int i = 0; i < MAX_POINTS; i++) begin
      write_point(i[5:0], pick_coord(), pick_coord(), pick_coord());
    end

    random_phase(70, 0, 0, 7'd4);
    random_phase(70, 75, 0, 7'd64);
    random_phase(70, 0, 75, 7'd37);
    random_phase(70, 19, 19, 7'd2);
    random_phase(70, 19, 19, 7'($urandom_range(127)));
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain();
    repeat (30) @(negedge clk);
    $display("run: %0d requests sent, %0d results checked", request_count, result_count);
    $display("covered: point counts 0..127, path ends, saturation, four idle patterns");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/crpe_pkg.sv
hw/rtl/crpe_req_if.sv
hw/rtl/crpe_res_if.sv
hw/rtl/crpe_prep.sv
hw/rtl/crpe_mem_seq.sv
hw/rtl/crpe_blend.sv
hw/rtl/crpe_out_queue.sv
hw/rtl/catmull_rom_path_evaluator.sv
bench/crpe_checker.sv
bench/testbench.sv
